@@ rtl/xbt_pkg.sv @@
// Shared types, character codes and result builders for the XML byte tokenizer.
package xbt_pkg;

    // Lexer mode, one-hot
    typedef enum logic [3:0] {
        MODE_BETWEEN = 4'b0001,
        MODE_TEXT    = 4'b0010,
        MODE_QUOTED  = 4'b0100,
        MODE_WORD    = 4'b1000
    } mode_t;

    // Token-end types
    localparam logic [1:0] TOK_OPEN   = 2'd0;
    localparam logic [1:0] TOK_CLOSE  = 2'd1;
    localparam logic [1:0] TOK_EQUAL  = 2'd2;
    localparam logic [1:0] TOK_STRING = 2'd3;

    // Result kinds
    localparam logic KIND_TEXT = 1'b0;
    localparam logic KIND_END  = 1'b1;

    // Characters of interest
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;

    localparam int unsigned MAX_RES = 3;

    typedef struct packed {
        logic       kind;
        logic [1:0] token_type;
        logic [7:0] byte_value;
    } res_t;

    // Outcome of lexing one byte
    typedef struct packed {
        res_t [MAX_RES-1:0] res;    // res[0] leaves first
        logic [1:0]         count;
        mode_t              mode_next;
        logic               esc_next;
    } dec_t;

    function automatic res_t mk_text(input logic [7:0] b);
        res_t r;
        r.kind       = KIND_TEXT;
        r.token_type = TOK_OPEN;
        r.byte_value = b;
        return r;
    endfunction

    function automatic res_t mk_end(input logic [1:0] t);
        res_t r;
        r.kind       = KIND_END;
        r.token_type = t;
        r.byte_value = 8'h00;
        return r;
    endfunction

endpackage

@@ rtl/xbt_if.sv @@
// Valid/ready channel interfaces for bytes in and token results out.
interface xbt_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;

    modport source (output valid, output byte_in, input ready);
    modport sink   (input valid, input byte_in, output ready);
endinterface

interface xbt_token_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [1:0] token_type;
    logic [7:0] byte_value;
    logic       last;

    modport source (output valid, output kind, output token_type, output byte_value,
                    output last, input ready);
    modport sink   (input valid, input kind, input token_type, input byte_value,
                    input last, output ready);
endinterface

@@ rtl/xbt_lexer.sv @@
// Combinational lexer: one byte in the current mode to up to three results.
module xbt_lexer
(
    input  xbt_pkg::mode_t mode,
    input  logic           esc,
    input  logic [7:0]     c,
    output xbt_pkg::dec_t  dec
);

    logic is_space;

    assign is_space = (c == xbt_pkg::CH_SPACE) || (c == xbt_pkg::CH_CR) ||
                      (c == xbt_pkg::CH_LF)    || (c == xbt_pkg::CH_TAB);

    always_comb
    begin
        dec           = '0;
        dec.mode_next = mode;
        dec.esc_next  = esc;
        unique case (mode)
            xbt_pkg::MODE_BETWEEN:
            begin
                priority if (c == xbt_pkg::CH_LT)
                begin
                    dec.res[0] = xbt_pkg::mk_text(c);
                    dec.res[1] = xbt_pkg::mk_end(xbt_pkg::TOK_OPEN);
                    dec.count  = 2'd2;
                end
                else if (c == xbt_pkg::CH_GT)
                begin
                    dec.res[0]    = xbt_pkg::mk_text(c);
                    dec.res[1]    = xbt_pkg::mk_end(xbt_pkg::TOK_CLOSE);
                    dec.count     = 2'd2;
                    dec.mode_next = xbt_pkg::MODE_TEXT;
                end
                else if (c == xbt_pkg::CH_EQ)
                begin
                    dec.res[0] = xbt_pkg::mk_text(c);
                    dec.res[1] = xbt_pkg::mk_end(xbt_pkg::TOK_EQUAL);
                    dec.count  = 2'd2;
                end
                else if (c == xbt_pkg::CH_QUOTE)
                begin
                    dec.mode_next = xbt_pkg::MODE_QUOTED;
                end
                else if (!is_space)
                begin
                    // starts a bare word; byte is its first character
                    dec.res[0]    = xbt_pkg::mk_text(c);
                    dec.count     = 2'd1;
                    dec.mode_next = xbt_pkg::MODE_WORD;
                end
                else
                begin
                    // whitespace between tags: skipped, no result
                    dec.count = 2'd0;
                end
            end
            xbt_pkg::MODE_TEXT:
            begin
                if (c == xbt_pkg::CH_LT)
                begin
                    dec.res[0]    = xbt_pkg::mk_end(xbt_pkg::TOK_CLOSE);
                    dec.res[1]    = xbt_pkg::mk_text(c);
                    dec.res[2]    = xbt_pkg::mk_end(xbt_pkg::TOK_OPEN);
                    dec.count     = 2'd3;
                    dec.mode_next = xbt_pkg::MODE_BETWEEN;
                end
                else
                begin
                    dec.res[0] = xbt_pkg::mk_text(c);
                    dec.count  = 2'd1;
                end
            end
            xbt_pkg::MODE_QUOTED:
            begin
                priority if (!esc && c == xbt_pkg::CH_QUOTE)
                begin
                    dec.res[0]    = xbt_pkg::mk_end(xbt_pkg::TOK_STRING);
                    dec.count     = 2'd1;
                    dec.mode_next = xbt_pkg::MODE_BETWEEN;
                end
                else if (!esc && c == xbt_pkg::CH_BSL)
                begin
                    dec.esc_next = 1'b1;
                end
                else
                begin
                    dec.res[0]   = xbt_pkg::mk_text(c);
                    dec.count    = 2'd1;
                    dec.esc_next = 1'b0;
                end
            end
            xbt_pkg::MODE_WORD:
            begin
                priority if (c == xbt_pkg::CH_SPACE)
                begin
                    dec.res[0]    = xbt_pkg::mk_end(xbt_pkg::TOK_STRING);
                    dec.count     = 2'd1;
                    dec.mode_next = xbt_pkg::MODE_BETWEEN;
                end
                else if (c == xbt_pkg::CH_LT)
                begin
                    dec.res[0]    = xbt_pkg::mk_end(xbt_pkg::TOK_STRING);
                    dec.res[1]    = xbt_pkg::mk_text(c);
                    dec.res[2]    = xbt_pkg::mk_end(xbt_pkg::TOK_OPEN);
                    dec.count     = 2'd3;
                    dec.mode_next = xbt_pkg::MODE_BETWEEN;
                end
                else if (c == xbt_pkg::CH_GT)
                begin
                    dec.res[0]    = xbt_pkg::mk_end(xbt_pkg::TOK_STRING);
                    dec.res[1]    = xbt_pkg::mk_text(c);
                    dec.res[2]    = xbt_pkg::mk_end(xbt_pkg::TOK_CLOSE);
                    dec.count     = 2'd3;
                    dec.mode_next = xbt_pkg::MODE_TEXT;
                end
                else if (c == xbt_pkg::CH_EQ)
                begin
                    dec.res[0]    = xbt_pkg::mk_end(xbt_pkg::TOK_STRING);
                    dec.res[1]    = xbt_pkg::mk_text(c);
                    dec.res[2]    = xbt_pkg::mk_end(xbt_pkg::TOK_EQUAL);
                    dec.count     = 2'd3;
                    dec.mode_next = xbt_pkg::MODE_BETWEEN;
                end
                else if (c == xbt_pkg::CH_QUOTE)
                begin
                    dec.res[0]    = xbt_pkg::mk_end(xbt_pkg::TOK_STRING);
                    dec.count     = 2'd1;
                    dec.mode_next = xbt_pkg::MODE_QUOTED;
                end
                else
                begin
                    dec.res[0] = xbt_pkg::mk_text(c);
                    dec.count  = 2'd1;
                end
            end
            default:
            begin
                dec.mode_next = xbt_pkg::MODE_BETWEEN;
                dec.esc_next  = 1'b0;
            end
        endcase
    end

endmodule

@@ rtl/xml_byte_tokenizer_top.sv @@
// XML byte tokenizer top level: input skid, lexer stage and result group register.
// Path: a byte's first result is offered once the byte has passed the stage register
// and then the result register, later while earlier results still wait.
// Throughput: one byte per cycle while each byte gives at most one result and the
// receiver is ready; a byte giving k results (k up to 3) holds the single result
// port until all k are taken. Reset (rst_n low, asynchronous): lexer back between
// tags, escape clear, all buffers empty; no clearing pass.
module xml_byte_tokenizer_top
(
    input  logic            clk,
    input  logic            rst_n,
    xbt_byte_if.sink        byte_stream,
    xbt_token_if.source     token_stream
);

    // Input side: ready is a register (skid empty), so the sink's ready never
    // waits on the far side of the block.
    logic                    skid_valid_reg, skid_valid_next;
    logic [7:0]              skid_byte_reg;
    logic                    stage_valid_reg, stage_valid_next;
    logic [7:0]              stage_byte_reg, stage_byte_next;

    // Lexer state, moves when a staged byte is decoded
    xbt_pkg::mode_t          mode_reg, mode_next;
    logic                    esc_reg, esc_next;

    // Results of one byte, res[0] at the head; one word out per cycle while ready
    xbt_pkg::res_t [xbt_pkg::MAX_RES-1:0] grp_reg, grp_next;
    logic [1:0]              cnt_reg, cnt_next;

    xbt_pkg::dec_t           dec;
    logic                    in_fire;
    logic                    out_fire;
    logic                    grp_free;
    logic                    stage_adv;

    xbt_lexer u_lexer
    (
        .mode (mode_reg),
        .esc  (esc_reg),
        .c    (stage_byte_reg),
        .dec  (dec)
    );

    assign byte_stream.ready = !skid_valid_reg;
    assign in_fire           = byte_stream.valid && !skid_valid_reg;

    assign token_stream.valid      = (cnt_reg != 2'd0);
    assign token_stream.kind       = grp_reg[0].kind;
    assign token_stream.token_type = grp_reg[0].token_type;
    assign token_stream.byte_value = grp_reg[0].byte_value;
    assign token_stream.last       = (cnt_reg == 2'd1);
    assign out_fire                = token_stream.valid && token_stream.ready;

    // Group can take a new byte's results when empty or emptying this cycle
    assign grp_free  = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && token_stream.ready);
    assign stage_adv = stage_valid_reg && grp_free;

    always_comb
    begin
        skid_valid_next  = skid_valid_reg;
        stage_valid_next = stage_valid_reg;
        stage_byte_next  = stage_byte_reg;
        if (!stage_valid_reg || stage_adv)
        begin
            // stage refills: older byte in skid first
            if (skid_valid_reg)
            begin
                stage_valid_next = 1'b1;
                stage_byte_next  = skid_byte_reg;
                skid_valid_next  = 1'b0;
            end
            else
            begin
                stage_valid_next = in_fire;
                stage_byte_next  = byte_stream.byte_in;
            end
        end
        else if (in_fire)
        begin
            skid_valid_next = 1'b1;
        end
    end

    always_comb
    begin
        mode_next = mode_reg;
        esc_next  = esc_reg;
        grp_next  = grp_reg;
        cnt_next  = cnt_reg;
        if (stage_adv)
        begin
            mode_next = dec.mode_next;
            esc_next  = dec.esc_next;
            grp_next  = dec.res;
            cnt_next  = dec.count;
        end
        else if (out_fire)
        begin
            grp_next[0] = grp_reg[1];
            grp_next[1] = grp_reg[2];
            cnt_next    = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skid_valid_reg  <= 1'b0;
            stage_valid_reg <= 1'b0;
            mode_reg        <= xbt_pkg::MODE_BETWEEN;
            esc_reg         <= 1'b0;
            cnt_reg         <= 2'd0;
        end
        else
        begin
            skid_valid_reg  <= skid_valid_next;
            stage_valid_reg <= stage_valid_next;
            mode_reg        <= mode_next;
            esc_reg         <= esc_next;
            cnt_reg         <= cnt_next;
        end
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        if (in_fire && stage_valid_reg && !stage_adv)
        begin
            skid_byte_reg <= byte_stream.byte_in;
        end
        stage_byte_reg <= stage_byte_next;
        grp_reg        <= grp_next;
    end

endmodule

@@ test/xml_byte_tokenizer_top_tb.sv @@
// Self-checking testbench for the XML byte tokenizer: directed and random byte streams.
`timescale 1ns / 100ps

module xml_byte_tokenizer_top_tb;

    // One expected word on the token channel
    typedef struct packed {
        logic       kind;
        logic [1:0] token_type;
        logic [7:0] byte_value;
        logic       last;
    } token_word_t;

    logic clk;
    logic rst_n;

    xbt_byte_if  byte_ch ();
    xbt_token_if token_ch ();

    xml_byte_tokenizer_top dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_stream  (byte_ch),
        .token_stream (token_ch)
    );

    // Lexer state as the block should hold it
    xbt_pkg::mode_t lex_mode;
    logic           lex_escape;

    // Words the block still owes us, oldest first
    token_word_t pending_tokens[$];

    // Idling controls, percent of cycles
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    // Long receiver hold-off, counted down by the ready process
    int unsigned hold_left;

    int unsigned mismatch_count;
    int unsigned bytes_sent;
    int unsigned live_bytes;      // bytes that changed state or gave results
    int unsigned tokens_checked;
    int unsigned triple_bytes;    // bytes that gave three words
    int unsigned token_ends;

    localparam int unsigned DRAIN_LIMIT = 50000;
    localparam int unsigned PRINT_LIMIT = 40;

    // ------------------------------------------------------------------
    // Clock, reset and run limit
    // ------------------------------------------------------------------
    initial clk = 1'b0;
    always #5 clk = ~clk;

    initial
    begin
        // Run limit; the worst case stays well under it.
        #5_000_000;
        $display("Timeout: %0d words still outstanding", pending_tokens.size());
        $display("Mismatches found");
        $finish;
    end

    // ------------------------------------------------------------------
    // Reporting
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
            $display("[%0t] MISMATCH %s: got 0x%0h, want 0x%0h", $time, what, got, want);
    endtask

    // ------------------------------------------------------------------
    // Predictor: lexes one byte, queues the words it should produce.
    // Returns the number of words.
    // ------------------------------------------------------------------
    function automatic token_word_t text_word(input logic [7:0] b);
        token_word_t w;
        w.kind       = xbt_pkg::KIND_TEXT;
        w.token_type = xbt_pkg::TOK_OPEN;
        w.byte_value = b;
        w.last       = 1'b0;
        return w;
    endfunction

    function automatic token_word_t end_word(input logic [1:0] t);
        token_word_t w;
        w.kind       = xbt_pkg::KIND_END;
        w.token_type = t;
        w.byte_value = 8'h00;
        w.last       = 1'b0;
        return w;
    endfunction

    function automatic int lex_byte(input logic [7:0] c);
        token_word_t out_words[$];
        int          pass;
        bit          again;
        for (pass = 0; pass < 3; pass++)
        begin
            again = 1'b0;
            case (lex_mode)
                xbt_pkg::MODE_BETWEEN:
                begin
                    if (c == xbt_pkg::CH_LT)
                    begin
                        out_words.push_back(text_word(c));
                        out_words.push_back(end_word(xbt_pkg::TOK_OPEN));
                    end
                    else if (c == xbt_pkg::CH_GT)
                    begin
                        out_words.push_back(text_word(c));
                        out_words.push_back(end_word(xbt_pkg::TOK_CLOSE));
                        lex_mode = xbt_pkg::MODE_TEXT;
                    end
                    else if (c == xbt_pkg::CH_EQ)
                    begin
                        out_words.push_back(text_word(c));
                        out_words.push_back(end_word(xbt_pkg::TOK_EQUAL));
                    end
                    else if (c == xbt_pkg::CH_QUOTE)
                        lex_mode = xbt_pkg::MODE_QUOTED;
                    else if (c != xbt_pkg::CH_SPACE && c != xbt_pkg::CH_CR &&
                             c != xbt_pkg::CH_LF && c != xbt_pkg::CH_TAB)
                    begin
                        // starts a bare word; same byte goes round again
                        lex_mode = xbt_pkg::MODE_WORD;
                        again    = 1'b1;
                    end
                end
                xbt_pkg::MODE_TEXT:
                begin
                    if (c == xbt_pkg::CH_LT)
                    begin
                        out_words.push_back(end_word(xbt_pkg::TOK_CLOSE));
                        lex_mode = xbt_pkg::MODE_BETWEEN;
                        again    = 1'b1;
                    end
                    else
                        out_words.push_back(text_word(c));
                end
                xbt_pkg::MODE_QUOTED:
                begin
                    if (!lex_escape && c == xbt_pkg::CH_QUOTE)
                    begin
                        out_words.push_back(end_word(xbt_pkg::TOK_STRING));
                        lex_mode = xbt_pkg::MODE_BETWEEN;
                    end
                    else if (!lex_escape && c == xbt_pkg::CH_BSL)
                        lex_escape = 1'b1;
                    else
                    begin
                        lex_escape = 1'b0;
                        out_words.push_back(text_word(c));
                    end
                end
                default:
                begin
                    if (c == xbt_pkg::CH_SPACE)
                    begin
                        // space ends the word and is dropped
                        out_words.push_back(end_word(xbt_pkg::TOK_STRING));
                        lex_mode = xbt_pkg::MODE_BETWEEN;
                    end
                    else if (c == xbt_pkg::CH_LT || c == xbt_pkg::CH_GT ||
                             c == xbt_pkg::CH_EQ || c == xbt_pkg::CH_QUOTE)
                    begin
                        out_words.push_back(end_word(xbt_pkg::TOK_STRING));
                        lex_mode = xbt_pkg::MODE_BETWEEN;
                        again    = 1'b1;
                    end
                    else
                        out_words.push_back(text_word(c));
                end
            endcase
            if (!again)
                break;
        end
        if (out_words.size() > 0)
            out_words[out_words.size()-1].last = 1'b1;
        for (pass = 0; pass < out_words.size(); pass++)
        begin
            pending_tokens.push_back(out_words[pass]);
            if (out_words[pass].kind == xbt_pkg::KIND_END)
                token_ends++;
        end
        return out_words.size();
    endfunction

    // ------------------------------------------------------------------
    // Byte sender. Called at a falling edge, returns at a falling edge with
    // valid still high, so back-to-back words never drop valid.
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b);
        xbt_pkg::mode_t mode_was;
        logic           esc_was;
        int             n;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            byte_ch.valid <= 1'b0;
            @(negedge clk);
        end
        byte_ch.valid   <= 1'b1;
        byte_ch.byte_in <= b;
        @(posedge clk);
        while (!byte_ch.ready)
            @(posedge clk);
        // accepted on this edge
        mode_was = lex_mode;
        esc_was  = lex_escape;
        n = lex_byte(b);
        bytes_sent++;
        if (n == 3)
            triple_bytes++;
        if (n > 0 || mode_was != lex_mode || esc_was != lex_escape)
            live_bytes++;
        @(negedge clk);
    endtask

    task automatic stop_sending();
        byte_ch.valid <= 1'b0;
        @(negedge clk);
    endtask

    // Waits for every owed word or for DRAIN_LIMIT, then lets the channel settle
    task automatic wait_tokens_drained();
        int unsigned cycles;
        cycles = 0;
        while (pending_tokens.size() != 0 && cycles < DRAIN_LIMIT)
        begin
            @(negedge clk);
            cycles++;
        end
        repeat (8) @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stalls, or a long counted hold-off when asked
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            token_ch.ready <= 1'b0;
            hold_left--;
        end
        else
            token_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // ------------------------------------------------------------------
    // Checker: every word taken off the token channel against the oldest
    // prediction
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        token_word_t want;
        if (rst_n && token_ch.valid && token_ch.ready)
        begin
            tokens_checked++;
            if (pending_tokens.size() == 0)
                report_mismatch("unexpected word, byte_value", token_ch.byte_value, 0);
            else
            begin
                want = pending_tokens.pop_front();
                if (token_ch.kind !== want.kind)
                    report_mismatch("kind", token_ch.kind, want.kind);
                if (token_ch.token_type !== want.token_type)
                    report_mismatch("token_type", token_ch.token_type, want.token_type);
                if (token_ch.byte_value !== want.byte_value)
                    report_mismatch("byte_value", token_ch.byte_value, want.byte_value);
                if (token_ch.last !== want.last)
                    report_mismatch("last", token_ch.last, want.last);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers for well-formed fragments
    // ------------------------------------------------------------------
    function automatic logic [7:0] rand_name_byte();
        logic [7:0] b;
        if ($urandom_range(0, 4) != 0)
            return 8'h61 + 8'($urandom_range(0, 25));
        b = 8'($urandom_range(0, 255));
        if (b == xbt_pkg::CH_LT || b == xbt_pkg::CH_GT || b == xbt_pkg::CH_EQ ||
            b == xbt_pkg::CH_QUOTE || b == xbt_pkg::CH_SPACE)
            b = 8'h5F;
        return b;
    endfunction

    task automatic send_name();
        int len;
        int k;
        len = $urandom_range(1, 4);
        for (k = 0; k < len; k++)
            send_byte(rand_name_byte());
    endtask

    // A space first, so a bare word is properly ended, then odd whitespace
    task automatic send_spaces();
        int len;
        int k;
        send_byte(xbt_pkg::CH_SPACE);
        len = $urandom_range(0, 2);
        for (k = 0; k < len; k++)
        begin
            case ($urandom_range(0, 3))
                0: send_byte(xbt_pkg::CH_SPACE);
                1: send_byte(xbt_pkg::CH_TAB);
                2: send_byte(xbt_pkg::CH_CR);
                default: send_byte(xbt_pkg::CH_LF);
            endcase
        end
    endtask

    task automatic send_quoted();
        int         len;
        int         k;
        logic [7:0] b;
        send_byte(xbt_pkg::CH_QUOTE);
        len = $urandom_range(0, 6);
        for (k = 0; k < len; k++)
        begin
            if ($urandom_range(0, 5) == 0)
            begin
                // escape followed by anything, quote and backslash included
                send_byte(xbt_pkg::CH_BSL);
                case ($urandom_range(0, 2))
                    0: send_byte(xbt_pkg::CH_QUOTE);
                    1: send_byte(xbt_pkg::CH_BSL);
                    default: send_byte(8'($urandom_range(0, 255)));
                endcase
            end
            else
            begin
                b = 8'($urandom_range(0, 255));
                if (b == xbt_pkg::CH_QUOTE || b == xbt_pkg::CH_BSL)
                    b = 8'h71;
                send_byte(b);
            end
        end
        // occasionally leave the string open
        if ($urandom_range(0, 9) != 0)
            send_byte(xbt_pkg::CH_QUOTE);
    endtask

    // One tag with attributes and trailing element text, or a burst of noise
    task automatic send_fragment();
        int         k;
        int         n;
        logic [7:0] b;
        if ($urandom_range(0, 99) < 15)
        begin
            n = $urandom_range(1, 4);
            for (k = 0; k < n; k++)
                send_byte(8'($urandom_range(0, 255)));
        end
        else
        begin
            send_byte(xbt_pkg::CH_LT);
            if ($urandom_range(0, 3) == 0)
                send_byte(8'h2F);
            send_name();
            n = $urandom_range(0, 2);
            for (k = 0; k < n; k++)
            begin
                send_spaces();
                send_name();
                if ($urandom_range(0, 3) == 0)
                    send_spaces();
                send_byte(xbt_pkg::CH_EQ);
                if ($urandom_range(0, 4) == 0)
                    send_name();
                else
                    send_quoted();
            end
            if ($urandom_range(0, 4) == 0)
                send_spaces();
            send_byte(xbt_pkg::CH_GT);
            n = $urandom_range(0, 5);
            for (k = 0; k < n; k++)
            begin
                b = 8'($urandom_range(0, 255));
                if (b == xbt_pkg::CH_LT)
                    b = 8'h74;
                send_byte(b);
            end
        end
    endtask

    task automatic send_random_items(input int unsigned count);
        int unsigned goal;
        goal = live_bytes + count;
        while (live_bytes < goal)
            send_fragment();
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Mode changes, three-word cases, escapes, byte extremes
    task automatic test_directed();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_byte(xbt_pkg::CH_SPACE);   // skipped between tags
        send_byte(xbt_pkg::CH_TAB);     // skipped
        send_byte(xbt_pkg::CH_LT);      // '<' and open end
        send_byte(8'h00);               // zero byte starts a bare word
        send_byte(xbt_pkg::CH_TAB);     // tab kept inside the word
        send_byte(xbt_pkg::CH_SPACE);   // space ends the word, dropped
        send_byte(8'hFF);               // new word
        send_byte(xbt_pkg::CH_EQ);      // word end, '=', equal end
        send_byte(xbt_pkg::CH_QUOTE);   // into quoted string
        send_byte(xbt_pkg::CH_BSL);     // escape
        send_byte(xbt_pkg::CH_QUOTE);   // escaped quote is text
        send_byte(xbt_pkg::CH_BSL);
        send_byte(xbt_pkg::CH_BSL);     // escaped backslash is text
        send_byte(8'hFF);
        send_byte(xbt_pkg::CH_QUOTE);   // string end
        send_byte(xbt_pkg::CH_GT);      // '>' and close end, element text follows
        send_byte(8'h00);
        send_byte(xbt_pkg::CH_SPACE);   // space is text here
        send_byte(xbt_pkg::CH_LT);      // text end, '<', open end
        send_byte(8'h62);
        send_byte(xbt_pkg::CH_GT);      // word end, '>', close end
        send_byte(xbt_pkg::CH_GT);      // plain text in element text
        send_byte(xbt_pkg::CH_LT);
        send_byte(xbt_pkg::CH_CR);
        send_byte(xbt_pkg::CH_LF);
        stop_sending();
        wait_tokens_drained();
    endtask

    task automatic test_random_free_flow();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_random_items(75);
    endtask

    task automatic test_random_sender_idle();
        send_idle_pct  = 78;
        recv_stall_pct = 0;
        send_random_items(75);
    endtask

    task automatic test_random_receiver_stall();
        send_idle_pct  = 0;
        recv_stall_pct = 78;
        send_random_items(75);
    endtask

    task automatic test_random_both_idle();
        send_idle_pct  = 22;
        recv_stall_pct = 22;
        send_random_items(75);
    endtask

    // Receiver held off long enough for the block to fill and stall its
    // input, then the sender waits for everything to come out; a half-stalled phase ends it
    task automatic test_backpressure();
        int k;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        stop_sending();
        @(posedge clk);
        hold_left = 200;
        @(negedge clk);
        for (k = 0; k < 12; k++)
        begin
            send_byte(8'h77);               // bare word
            send_byte(xbt_pkg::CH_EQ);      // three words
            send_byte(xbt_pkg::CH_GT);      // two words, element text
            send_byte(xbt_pkg::CH_LT);      // three words
        end
        send_random_items(30);
        stop_sending();
        wait_tokens_drained();
        recv_stall_pct = 50;
        send_random_items(20);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n           = 1'b0;
        byte_ch.valid   = 1'b0;
        byte_ch.byte_in = 8'h00;
        token_ch.ready  = 1'b0;
        lex_mode        = xbt_pkg::MODE_BETWEEN;
        lex_escape      = 1'b0;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        hold_left       = 0;
        mismatch_count  = 0;
        bytes_sent      = 0;
        live_bytes      = 0;
        tokens_checked  = 0;
        triple_bytes    = 0;
        token_ends      = 0;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed();
        test_random_free_flow();
        test_random_sender_idle();
        test_random_receiver_stall();
        test_random_both_idle();
        test_backpressure();

        stop_sending();
        wait_tokens_drained();
        while (pending_tokens.size() != 0)
        begin
            report_mismatch("word never arrived, byte_value",
                            -1, pending_tokens[0].byte_value);
            void'(pending_tokens.pop_front());
        end

        $display("Sent %0d bytes (%0d effective, %0d giving three words); checked %0d words",
                 bytes_sent, live_bytes, triple_bytes, tokens_checked);
        $display("Token ends seen: %0d; idling phases plus a %0d-cycle receiver hold-off",
                 token_ends, 200);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
